/* design/ghash_gf128_multiply_accumulate_unit_assert.svh */
// ---------------------------------------------------------------------------
// GHASH unit assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GHASH_GF128_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH
`define GHASH_GF128_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GHASH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GHASH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ghash_pkg.sv */
// ---------------------------------------------------------------------------
// GHASH package
// Payload types and register indexes for the GHASH multiply-accumulate unit,
// and the field polynomial for its multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

package ghash_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_SUBKEY_HIGH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SUBKEY_LOW  = 2'd1;

    // Low terms of x^128 + x^7 + x^2 + x + 1
    localparam logic [7:0] GCM_POLY_TAIL = 8'h87;

    typedef struct packed {
        logic        command;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } ghash_req_t;

    typedef struct packed {
        logic [63:0] hash_high;
        logic [63:0] hash_low;
    } ghash_rsp_t;

endpackage

`default_nettype wire

/* design/ghash_gf128_multiply_accumulate_unit.sv */
// ---------------------------------------------------------------------------
// GHASH multiply-accumulate unit
// Keeps the running GCM hash Y and replaces it with (Y xor X) * H for each
// request, or with X * H on a restart; the updated Y is returned for every request.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    command, block_high, block_low
//  rsp      out        rsp_valid/stall    hash_high, hash_low
//  cfg      in         cfg_we             cfg_index, cfg_wdata (subkey halves)
//
//  One request per cycle sustained while rsp_stall is low; an accepted
//  request passes through the request stage register into the output register.
//  The sustained rate rests on the combinational field multiplier, whose result
//  feeds the accumulator for the request directly behind it.
//  Reset clears the subkey, the accumulator and both valid flags.
//  A stalled result holds in the output register; the request stage
//  stalls the input only when it is full and the output cannot drain.
// ---------------------------------------------------------------------------
`default_nettype none

module ghash_gf128_multiply_accumulate_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire ghash_pkg::ghash_req_t              req_data,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output ghash_pkg::ghash_rsp_t                   rsp_data,
    input  wire logic                               cfg_we,
    input  wire logic [ghash_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [ghash_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ghash_pkg::*;

    logic [127:0] subkey_reg;
    logic         stage_valid_reg;
    logic         stage_valid_next;
    ghash_req_t   stage_reg;
    logic [127:0] acc_reg;
    logic [127:0] out_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         req_accept;
    logic         fire;
    logic [127:0] mul_x;
    logic [127:0] product;

    // subkey registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subkey_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SUBKEY_HIGH: subkey_reg[127:64] <= cfg_wdata;
                REG_SUBKEY_LOW:  subkey_reg[63:0]   <= cfg_wdata;
                default:         subkey_reg         <= subkey_reg;
            endcase
        end
    end

    // advance the stage whenever the output register is free or draining
    assign fire       = stage_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall  = stage_valid_reg && !fire;
    assign req_accept = req_valid && !req_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (req_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            stage_reg <= req_data;
        end
    end

    // drop the running hash on restart
    assign mul_x = (stage_reg.command ? 128'b0 : acc_reg)
                 ^ {stage_reg.block_high, stage_reg.block_low};

    ghash_mul u_mul (
        .x (mul_x),
        .h (subkey_reg),
        .p (product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (fire)
        begin
            acc_reg <= product;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= product;
        end
    end

    assign rsp_valid          = out_valid_reg;
    assign rsp_data.hash_high = out_reg[127:64];
    assign rsp_data.hash_low  = out_reg[63:0];

`include "ghash_gf128_multiply_accumulate_unit_assert.svh"

    `GHASH_ASSERT_NEXT(a_acc_matches_out, fire, acc_reg == out_reg, "accumulator differs from result")
    `GHASH_ASSERT_NEXT(a_zero_key_zero_hash, fire && (subkey_reg == 128'b0), out_reg == 128'b0, "zero subkey gave nonzero hash")
    `GHASH_ASSERT_NEXT(a_req_lands_in_stage, req_accept, stage_valid_reg, "accepted request lost")
    `GHASH_ASSERT_NEXT(a_drained_out_clears, out_valid_reg && !rsp_stall && !fire, !out_valid_reg, "delivered result repeated")
    `GHASH_ASSERT_SAME(a_stall_only_when_full, req_stall, stage_valid_reg && out_valid_reg && rsp_stall, "request stalled without back-pressure")

endmodule

`default_nettype wire

/* design/ghash_mul.sv */
// ---------------------------------------------------------------------------
// GHASH field multiplier
// Combinational GF(2^128) product in GCM bit order: carry-less multiply
// followed by a two-step fold by the GCM polynomial.
// ---------------------------------------------------------------------------
`default_nettype none

module ghash_mul (
    input  wire logic [127:0] x,
    input  wire logic [127:0] h,
    output logic      [127:0] p
);
    import ghash_pkg::*;

    // GCM puts coefficient x^0 in the most significant bit of byte 0
    function automatic logic [127:0] bitrev128(input logic [127:0] v);
        logic [127:0] r;
        for (int i = 0; i < 128; i++)
        begin
            r[i] = v[127-i];
        end
        return r;
    endfunction

    logic [127:0] a;
    logic [127:0] b;
    logic [254:0] prod;
    logic [126:0] hi;
    logic [133:0] fold1;
    logic [5:0]   fold1_hi;
    logic [13:0]  fold2;
    logic [127:0] res;

    always_comb
    begin
        a = bitrev128(x);
        b = bitrev128(h);
        // each product coefficient is an XOR over its own diagonal
        prod = '0;
        for (int k = 0; k < 255; k++)
        begin
            for (int i = 0; i < 128; i++)
            begin
                if ((k - i >= 0) && (k - i < 128))
                begin
                    prod[k] = prod[k] ^ (a[i] & b[k-i]);
                end
            end
        end

        hi = prod[254:128];
        // fold the high half back by the polynomial tail
        fold1 = '0;
        for (int s = 0; s < 8; s++)
        begin
            if (GCM_POLY_TAIL[s])
            begin
                fold1 = fold1 ^ ({7'b0, hi} << s);
            end
        end

        // bits that spilled past x^127 need one more, short fold
        fold1_hi = fold1[133:128];
        fold2 = '0;
        for (int s = 0; s < 8; s++)
        begin
            if (GCM_POLY_TAIL[s])
            begin
                fold2 = fold2 ^ ({8'b0, fold1_hi} << s);
            end
        end

        res = prod[127:0] ^ fold1[127:0] ^ {114'b0, fold2};
        p   = bitrev128(res);
    end

endmodule

`default_nettype wire

/* tb/ghash_gf128_multiply_accumulate_unit_tb.sv */
// ---------------------------------------------------------------------------
// GHASH multiply-accumulate unit testbench
// Drives GCM blocks through the request channel and checks every returned
// hash against a bit-level GF(2^128) model kept alongside the block. Runs a
// short directed set over subkey extremes, then restart/absorb messages with
// random content under several subkeys, with random idling on both sides but for the closing stretch.
// ---------------------------------------------------------------------------
`default_nettype none

module ghash_gf128_multiply_accumulate_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ghash_pkg::*;

    localparam logic CMD_ABSORB  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_3 = 2'd3;

    // Reduction constant of the GCM polynomial in reflected bit order
    localparam logic [127:0] GCM_REDUCE = {8'he1, 120'd0};

    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;

    localparam int LONG_HOLD_CYCLES = 150;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    ghash_req_t             req_data = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    ghash_rsp_t             rsp_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    ghash_req_t   pending_requests[$];
    ghash_rsp_t   hash_expected[$];
    logic [127:0] subkey_model = '0;
    logic [127:0] running_hash = '0;

    int  requests_taken = 0;
    int  errors = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  hold_go = 1'b0;
    bit  idling = 1'b0;

    ghash_gf128_multiply_accumulate_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // (Y xor X) * H in GF(2^128), GCM bit order, with Y zero on a restart; advances the running hash
    function automatic ghash_rsp_t ghash_absorb(input ghash_req_t req);
        logic [127:0] y;
        logic [127:0] z;
        logic [127:0] v;
        ghash_rsp_t   rsp;
        y = (req.command == CMD_RESTART) ? 128'd0 : running_hash;
        y ^= {req.block_high, req.block_low};
        z = '0;
        v = subkey_model;
        for (int i = 127; i >= 0; i--)
        begin
            if (y[i])
                z ^= v;
            v = v[0] ? ((v >> 1) ^ GCM_REDUCE) : (v >> 1);
        end
        running_hash = z;
        rsp.hash_high = z[127:64];
        rsp.hash_low = z[63:0];
        return rsp;
    endfunction

    function automatic logic [63:0] random_word();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return ALL_ONES;
        else
            return {$urandom, $urandom};
    endfunction

    task automatic add_request(input logic cmd, input logic [63:0] hi, input logic [63:0] lo);
        ghash_req_t req;
        req.command = cmd;
        req.block_high = hi;
        req.block_low = lo;
        pending_requests.push_back(req);
    endtask

    // Messages open with a restart; a few are broken or carry stray restarts
    task automatic add_messages(input int count);
        int  added;
        int  len;
        bit  broken;
        logic cmd;
        added = 0;
        while (added < count)
        begin
            len = $urandom_range(1, 12);
            broken = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len && added < count; k++)
            begin
                cmd = (k == 0 && !broken) ? CMD_RESTART : CMD_ABSORB;
                if ($urandom_range(0, 19) == 0)
                    cmd = 1'($urandom_range(0, 1));
                add_request(cmd, random_word(), random_word());
                added++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_SUBKEY_HIGH)
            subkey_model[127:64] = value;
        else if (idx == REG_SUBKEY_LOW)
            subkey_model[63:0] = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_subkey(input logic [63:0] hi, input logic [63:0] lo);
        write_reg(REG_SUBKEY_HIGH, hi);
        write_reg(REG_SUBKEY_LOW, lo);
    endtask

    // Hold until every request is out and every hash has come back
    task automatic settle();
        while (pending_requests.size() != 0 || req_valid || hash_expected.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                hash_expected.push_back(ghash_absorb(req_data));
                requests_taken++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left != 0)
                begin
                    req_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_requests.size() != 0)
                begin
                    req_valid <= 1'b1;
                    req_data <= pending_requests.pop_front();
                    if (idling && $urandom_range(0, 7) == 0)
                        gap_left <= $urandom_range(1, 18);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_left != 0)
            rsp_stall <= 1'b1;
        else if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idling && $urandom_range(0, 11) == 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 17);
        end
        else
            rsp_stall <= 1'b0;
    end

    // Hash monitor
    always @(posedge clk)
    begin
        ghash_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (hash_expected.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected hash %h_%h", rsp_data.hash_high, rsp_data.hash_low);
            end
            else
            begin
                want = hash_expected.pop_front();
                if (rsp_data.hash_high !== want.hash_high
                    || rsp_data.hash_low !== want.hash_low)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("hash mismatch: expected %h_%h got %h_%h",
                                 want.hash_high, want.hash_low,
                                 rsp_data.hash_high, rsp_data.hash_low);
                end
            end
        end
    end

    initial
    begin
        int base;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero subkey straight out of reset, first request absorbs without restart
        add_request(CMD_ABSORB, ALL_ONES, ALL_ONES);
        add_request(CMD_RESTART, TOP_BIT, 64'd0);
        add_request(CMD_ABSORB, {$urandom, $urandom}, {$urandom, $urandom});
        settle();

        // Unmapped indexes must leave the subkey alone
        set_subkey(ALL_ONES, ALL_ONES);
        write_reg(REG_UNMAPPED_2, 64'h0123_4567_89ab_cdef);
        write_reg(REG_UNMAPPED_3, ALL_ONES);
        @(negedge clk);
        add_request(CMD_ABSORB, 64'd0, 64'd0);
        add_request(CMD_ABSORB, ALL_ONES, ALL_ONES);
        add_request(CMD_ABSORB, ALL_ONES, ALL_ONES);
        add_request(CMD_RESTART, 64'd0, 64'd0);
        add_request(CMD_RESTART, TOP_BIT, 64'd0);
        add_request(CMD_ABSORB, 64'd0, 64'd1);
        add_request(CMD_RESTART, ALL_ONES, 64'd0);
        add_request(CMD_RESTART, 64'd0, ALL_ONES);
        settle();

        // Multiplicative identity
        set_subkey(TOP_BIT, 64'd0);
        @(negedge clk);
        add_request(CMD_RESTART, {$urandom, $urandom}, {$urandom, $urandom});
        add_request(CMD_ABSORB, {$urandom, $urandom}, {$urandom, $urandom});
        add_request(CMD_ABSORB, 64'd0, 64'd1);
        add_request(CMD_ABSORB, ALL_ONES, ALL_ONES);
        settle();

        // Lowest bit of H only (x^127 in GCM bit order): products run through the reduction
        set_subkey(64'd0, 64'd1);
        @(negedge clk);
        add_request(CMD_RESTART, ALL_ONES, ALL_ONES);
        add_request(CMD_ABSORB, 64'd0, 64'd1);
        add_request(CMD_ABSORB, {$urandom, $urandom}, {$urandom, $urandom});
        settle();

        set_subkey({$urandom, $urandom}, {$urandom, $urandom});
        @(negedge clk);
        idling = 1'b1;
        base = requests_taken;
        add_messages(700);
        while (requests_taken < base + 250)
            @(negedge clk);
        hold_go = 1'b1;
        settle();

        set_subkey({$urandom, $urandom}, {$urandom, $urandom});
        @(negedge clk);
        add_messages(700);
        settle();

        // Closing stretch at full rate
        set_subkey({$urandom, $urandom}, {$urandom, $urandom});
        @(negedge clk);
        idling = 1'b0;
        add_messages(600);
        settle();

        if (errors == 0)
            $display("ghash_gf128_multiply_accumulate_unit_tb: clean");
        else
            $display("ghash_gf128_multiply_accumulate_unit_tb: errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("ghash_gf128_multiply_accumulate_unit_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
